[sv/multi_axis_stepper_positioner_unit_macros.svh]
// assertion macros for the positioner rtl
`ifndef MULTI_AXIS_STEPPER_POSITIONER_UNIT_MACROS_SVH
`define MULTI_AXIS_STEPPER_POSITIONER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked out of reset
`define MSP_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("msp check failed");

// next-cycle implication, checked out of reset
`define MSP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("msp check failed");

`else

`define MSP_ASSERT_NOW(label, clk, rstn, ante, cons)
`define MSP_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

[sv/msp_pkg.sv]
package msp_pkg;

    localparam int AXIS_MAX = 12;

    // per-axis zero offsets in microsteps
    localparam logic [10:0] AXIS_OFFSET [AXIS_MAX] = '{
        11'd455, 11'd0, 11'd520, 11'd0, 11'd230, 11'd0,
        11'd65,  11'd0, 11'd335, 11'd0, 11'd1005, 11'd0
    };

    localparam logic [7:0] CHAR_AXIS_FIRST = 8'd97;   // 'a'
    localparam logic [7:0] CHAR_AXIS_LAST  = 8'd108;  // 'l'
    localparam logic [7:0] CHAR_HOME       = 8'd48;   // '0'
    localparam logic [7:0] CHAR_POS_FIRST  = 8'd49;   // '1'
    localparam logic [7:0] CHAR_POS_LAST   = 8'd59;   // ';'

    localparam logic OP_COMMAND = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_MOVE   = 2'd1;
    localparam logic [1:0] MODE_HOME   = 2'd2;
    localparam logic [1:0] MODE_WIGGLE = 2'd3;

    localparam logic [2:0] ST_NONE      = 3'd0;
    localparam logic [2:0] ST_BAD_AXIS  = 3'd1;
    localparam logic [2:0] ST_BAD_POS   = 3'd2;
    localparam logic [2:0] ST_HOMING    = 3'd3;
    localparam logic [2:0] ST_MOVING    = 3'd4;
    localparam logic [2:0] ST_THERE     = 3'd5;
    localparam logic [2:0] ST_MOVE_DONE = 3'd6;
    localparam logic [2:0] ST_HOME_SEEN = 3'd7;

    localparam logic [2:0] WIGGLE_FIRST_PASS = 3'd6;

endpackage

[sv/multi_axis_stepper_positioner_unit.sv]
// Stepper positioner for up to twelve axes sharing one step/direction pair.
// Input stream (s_axis_*): tuser selects the request kind, 0 = command, 1 = tick.
//   A command carries an axis letter 'a'..'l' and a position character,
//   '0' to home the axis or '1'..';' to move to switch position 1..11.
//   A tick carries the home switch level of the active axis and advances the
//   running move, homing or anti-backlash wiggle by at most one step.
// Output stream (m_axis_*): exactly one result per request, holding the step
//   pulse, direction, active axis, its driver enable (low active), a status
//   code, the axis position and the current target.
// The result is registered: a request's result appears in the cycle after it is taken.
//   One request per cycle is sustained while the receiver takes results; the whole
//   update is a single pass between the input handshake and the output register.
// The output register lets a new request in whenever it is empty or being
//   taken in the same cycle; while the receiver stalls a full register,
//   s_axis_tready is low and all state holds.
// Reset (aresetn low, synchronous) clears all positions, selects axis 0,
//   stops any run and disables every driver; the output register is empty.
`include "multi_axis_stepper_positioner_unit_macros.svh"

module multi_axis_stepper_positioner_unit #(
    parameter int MICROSTEPS_PER_STEP = 8,
    parameter int AXIS_COUNT          = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] axis_char, [15:8] position_char, [16] home_switch, rest zero
    input  logic [23:0] s_axis_tdata,
    // [0] opcode
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] step_pulse, [1] direction, [5:2] axis_index, [6] driver_enable_n,
    // [9:7] status, [21:10] position, [33:22] target, rest zero
    output logic [39:0] m_axis_tdata
);

    localparam int AIDX_W   = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;
    localparam int LEFT_MAX = 12 * MICROSTEPS_PER_STEP;
    localparam int LEFT_W   = $clog2(LEFT_MAX + 1);
    localparam int STEP_Q   = 4 * MICROSTEPS_PER_STEP;
    localparam int STEP_HALF = 2 * MICROSTEPS_PER_STEP;
    localparam int K_SCALE  = (200 * MICROSTEPS_PER_STEP) / 12;
    localparam logic [LEFT_W-1:0] LEFT_FIRST = LEFT_W'(6 * MICROSTEPS_PER_STEP);

    // target table per axis and switch position, worked out at elaboration
    logic [11:0] tgt_tab [AXIS_COUNT][16];

    for (genvar ga = 0; ga < AXIS_COUNT; ga++) begin : g_axis
        for (genvar gk = 0; gk < 16; gk++) begin : g_pos
            localparam int V = K_SCALE * gk - int'(msp_pkg::AXIS_OFFSET[ga]);
            localparam int R = V % STEP_Q;
            localparam int T = (R == 0) ? V : ((R >= STEP_HALF) ? V + STEP_Q - R : V - R);
            localparam logic [11:0] TV = (gk >= 1 && gk <= 11) ? 12'(T) : 12'd0;
            assign tgt_tab[ga][gk] = TV;
        end
    end

    // state
    logic [11:0]       pos_reg [AXIS_COUNT];
    logic              en_n_reg [AXIS_COUNT];
    logic [3:0]        sel_reg, sel_next;
    logic [11:0]       tgt_reg, tgt_next;
    logic [1:0]        mode_reg, mode_next;
    logic              dir_reg, dir_next;
    logic [2:0]        pass_reg, pass_next;
    logic [LEFT_W-1:0] left_reg, left_next;

    // output register
    logic              m_valid_reg;
    logic [39:0]       m_data_reg, m_data_next;

    logic              in_fire;
    logic              op;
    logic [7:0]        ac, pc;
    logic              sw;
    logic [7:0]        ac_off;
    logic [3:0]        k_idx;
    logic              axis_ok;
    logic [AIDX_W-1:0] idx;
    logic [11:0]       pos_cur, pos_new, pos_step;
    logic              en_n_cur, en_n_new;
    logic [11:0]       tab_cmd, tab_home;
    logic              pulse;
    logic [2:0]        status;
    logic [LEFT_W-1:0] left_dec;
    logic [2:0]        pass_dec;
    logic [3:0]        pass_sum;

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    assign op = s_axis_tuser;
    assign ac = s_axis_tdata[7:0];
    assign pc = s_axis_tdata[15:8];
    assign sw = s_axis_tdata[16];

    assign ac_off  = ac - msp_pkg::CHAR_AXIS_FIRST;
    assign k_idx   = 4'(pc - msp_pkg::CHAR_HOME);
    assign axis_ok = (ac >= msp_pkg::CHAR_AXIS_FIRST) && (ac <= msp_pkg::CHAR_AXIS_LAST)
                     && (ac_off < 8'(AXIS_COUNT));

    // one read/write index: the commanded axis on a good command, else the active one
    assign idx = (op == msp_pkg::OP_COMMAND && axis_ok) ? ac_off[AIDX_W-1:0]
                                                        : sel_reg[AIDX_W-1:0];

    assign pos_cur  = pos_reg[idx];
    assign en_n_cur = en_n_reg[idx];
    assign tab_cmd  = tgt_tab[idx][k_idx];
    assign tab_home = tgt_tab[idx][1];
    assign pos_step = dir_reg ? pos_cur - 12'd1 : pos_cur + 12'd1;
    assign left_dec = (left_reg != '0) ? left_reg - LEFT_W'(1) : '0;
    assign pass_dec = pass_reg - 3'd1;
    assign pass_sum = {1'b0, pass_dec} + {1'b0, pass_reg};

    always_comb begin
        sel_next  = sel_reg;
        tgt_next  = tgt_reg;
        mode_next = mode_reg;
        dir_next  = dir_reg;
        pass_next = pass_reg;
        left_next = left_reg;
        pos_new   = pos_cur;
        en_n_new  = en_n_cur;
        pulse     = 1'b0;
        status    = msp_pkg::ST_NONE;

        if (op == msp_pkg::OP_COMMAND) begin
            priority if (!axis_ok) begin
                status = msp_pkg::ST_BAD_AXIS;
            end else if (pc == msp_pkg::CHAR_HOME) begin
                sel_next  = ac_off[3:0];
                tgt_next  = 12'hFFF;
                dir_next  = !pos_cur[11];
                en_n_new  = 1'b0;
                mode_next = msp_pkg::MODE_HOME;
                status    = msp_pkg::ST_HOMING;
            end else if (pc >= msp_pkg::CHAR_POS_FIRST && pc <= msp_pkg::CHAR_POS_LAST) begin
                sel_next = ac_off[3:0];
                tgt_next = tab_cmd;
                if (tab_cmd == pos_cur) begin
                    mode_next = msp_pkg::MODE_IDLE;
                    status    = msp_pkg::ST_THERE;
                end else begin
                    dir_next  = $signed(tab_cmd) < $signed(pos_cur);
                    en_n_new  = 1'b0;
                    mode_next = msp_pkg::MODE_MOVE;
                    status    = msp_pkg::ST_MOVING;
                end
            end else begin
                sel_next  = ac_off[3:0];
                mode_next = msp_pkg::MODE_IDLE;
                status    = msp_pkg::ST_BAD_POS;
            end
        end else begin
            unique case (mode_reg)
                msp_pkg::MODE_IDLE: begin
                end
                msp_pkg::MODE_MOVE: begin
                    pulse   = 1'b1;
                    pos_new = pos_step;
                    if (pos_step == tgt_reg) begin
                        mode_next = msp_pkg::MODE_WIGGLE;
                        pass_next = msp_pkg::WIGGLE_FIRST_PASS;
                        left_next = LEFT_FIRST;
                        dir_next  = 1'b1;
                    end
                end
                msp_pkg::MODE_HOME: begin
                    if (sw) begin
                        en_n_new = 1'b0;
                        pos_new  = 12'd0;
                        tgt_next = tab_home;
                        dir_next = tab_home[11];
                        status   = msp_pkg::ST_HOME_SEEN;
                        // already at position 1 after zeroing: straight to the wiggle
                        if (tab_home == 12'd0) begin
                            mode_next = msp_pkg::MODE_WIGGLE;
                            pass_next = msp_pkg::WIGGLE_FIRST_PASS;
                            left_next = LEFT_FIRST;
                            dir_next  = 1'b1;
                        end else begin
                            mode_next = msp_pkg::MODE_MOVE;
                        end
                    end else begin
                        pulse = 1'b1;
                    end
                end
                msp_pkg::MODE_WIGGLE: begin
                    pulse     = 1'b1;
                    pos_new   = pos_step;
                    left_next = left_dec;
                    if (left_dec == '0) begin
                        if (pass_reg == 3'd0) begin
                            mode_next = msp_pkg::MODE_IDLE;
                            en_n_new  = 1'b1;
                            status    = msp_pkg::ST_MOVE_DONE;
                        end else begin
                            pass_next = pass_dec;
                            left_next = LEFT_W'(int'(pass_sum) * MICROSTEPS_PER_STEP);
                            dir_next  = !pass_dec[0];
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        m_data_next        = '0;
        m_data_next[0]     = pulse;
        m_data_next[1]     = dir_next;
        m_data_next[5:2]   = sel_next;
        m_data_next[6]     = en_n_new;
        m_data_next[9:7]   = status;
        m_data_next[21:10] = pos_new;
        m_data_next[33:22] = tgt_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < AXIS_COUNT; i++) begin
                pos_reg[i]  <= 12'd0;
                en_n_reg[i] <= 1'b1;
            end
            sel_reg     <= 4'd0;
            tgt_reg     <= 12'd0;
            mode_reg    <= msp_pkg::MODE_IDLE;
            dir_reg     <= 1'b0;
            pass_reg    <= 3'd0;
            left_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (in_fire) begin
                pos_reg[idx]  <= pos_new;
                en_n_reg[idx] <= en_n_new;
                sel_reg       <= sel_next;
                tgt_reg       <= tgt_next;
                mode_reg      <= mode_next;
                dir_reg       <= dir_next;
                pass_reg      <= pass_next;
                left_reg      <= left_next;
                m_valid_reg   <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            m_data_reg <= m_data_next;
        end
    end

    // a run in progress always has the active axis driver enabled
    `MSP_ASSERT_NOW(a_run_enabled, aclk, aresetn,
        mode_reg != msp_pkg::MODE_IDLE, en_n_reg[sel_reg[AIDX_W-1:0]] == 1'b0)
    // homing keeps the all-ones target
    `MSP_ASSERT_NOW(a_home_target, aclk, aresetn,
        mode_reg == msp_pkg::MODE_HOME, tgt_reg == 12'hFFF)
    // wiggle pass never exceeds the first pass
    `MSP_ASSERT_NOW(a_pass_range, aclk, aresetn,
        1'b1, pass_reg <= msp_pkg::WIGGLE_FIRST_PASS)
    // home found: no step, position zeroed
    `MSP_ASSERT_NOW(a_home_result, aclk, aresetn,
        m_valid_reg && m_data_reg[9:7] == msp_pkg::ST_HOME_SEEN,
        m_data_reg[0] == 1'b0 && m_data_reg[21:10] == 12'd0)
    // a finished wiggle leaves the driver disabled and the block idle
    `MSP_ASSERT_NEXT(a_done_idle, aclk, aresetn,
        in_fire && status == msp_pkg::ST_MOVE_DONE,
        mode_reg == msp_pkg::MODE_IDLE && m_data_reg[6] == 1'b1)

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    localparam int USTEPS        = 8;
    localparam int AXES          = 12;
    localparam int STEPS_PER_POS = 200 * USTEPS / 12;
    localparam int ROUND_STEP    = 4 * USTEPS;
    localparam int PHASE_ITEMS   = 190;
    localparam int ITEMS         = 750;

    typedef struct packed {
        logic       opcode;
        logic [7:0] axis_char;
        logic [7:0] position_char;
        logic       home_switch;
    } request_t;

    typedef struct packed {
        logic        step_pulse;
        logic        direction;
        logic [3:0]  axis_index;
        logic        driver_enable_n;
        logic [2:0]  status;
        logic [11:0] position;
        logic [11:0] target;
    } result_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;

    multi_axis_stepper_positioner_unit #(
        .MICROSTEPS_PER_STEP(USTEPS),
        .AXIS_COUNT(AXES)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // positioner state as predicted from accepted requests
    logic [11:0] axis_pos [AXES];
    logic        axis_enable_n [AXES];
    logic [3:0]  cur_axis;
    logic [11:0] goal;
    logic [1:0]  run_state;
    logic        dir_line;
    int          wiggle_pass;
    int          wiggle_left;

    request_t pending_requests [$];
    result_t  expected_results [$];
    request_t offered;

    int  pushed_count   = 0;
    int  accepted_count = 0;
    int  result_count   = 0;
    int  mismatches     = 0;
    int  moves_done     = 0;
    int  homes_found    = 0;
    int  bad_commands   = 0;
    logic hold_off      = 1'b0;

    wire [1:0] idle_phase = 2'((accepted_count / PHASE_ITEMS) % 4);

    initial begin
        for (int i = 0; i < AXES; i++) begin
            axis_pos[i]      = '0;
            axis_enable_n[i] = 1'b1;
        end
        cur_axis    = '0;
        goal        = '0;
        run_state   = msp_pkg::MODE_IDLE;
        dir_line    = 1'b0;
        wiggle_pass = 0;
        wiggle_left = 0;
    end

    // switch position k of an axis, rounded to whole full steps x4
    function automatic logic [11:0] switch_target(input int k, input int a);
        int v;
        int r;
        v = STEPS_PER_POS * k - int'(msp_pkg::AXIS_OFFSET[a]);
        r = v % ROUND_STEP;
        if (r >= ROUND_STEP / 2)
            v = v + ROUND_STEP - r;
        else
            v = v - r;
        return v[11:0];
    endfunction

    function automatic void start_wiggle();
        run_state   = msp_pkg::MODE_WIGGLE;
        wiggle_pass = msp_pkg::WIGGLE_FIRST_PASS;
        wiggle_left = msp_pkg::WIGGLE_FIRST_PASS * USTEPS;
        dir_line    = 1'b1;
    endfunction

    function automatic void take_step(input int a);
        axis_pos[a] = dir_line ? axis_pos[a] - 12'd1 : axis_pos[a] + 12'd1;
    endfunction

    function automatic void advance_positioner(input request_t rq, output result_t res);
        logic        pulse;
        logic [2:0]  st;
        logic [11:0] d;
        int          a;
        int          last;
        pulse = 1'b0;
        st    = msp_pkg::ST_NONE;
        if (rq.opcode == msp_pkg::OP_COMMAND) begin
            if (rq.axis_char < msp_pkg::CHAR_AXIS_FIRST
                    || rq.axis_char > msp_pkg::CHAR_AXIS_LAST
                    || int'(rq.axis_char - msp_pkg::CHAR_AXIS_FIRST) >= AXES) begin
                st = msp_pkg::ST_BAD_AXIS;
            end else begin
                cur_axis = 4'(rq.axis_char - msp_pkg::CHAR_AXIS_FIRST);
                a = cur_axis;
                if (rq.position_char == msp_pkg::CHAR_HOME) begin
                    goal             = 12'hFFF;
                    dir_line         = ~axis_pos[a][11];
                    axis_enable_n[a] = 1'b0;
                    run_state        = msp_pkg::MODE_HOME;
                    st               = msp_pkg::ST_HOMING;
                end else if (rq.position_char >= msp_pkg::CHAR_POS_FIRST
                        && rq.position_char <= msp_pkg::CHAR_POS_LAST) begin
                    d    = switch_target(int'(rq.position_char - msp_pkg::CHAR_HOME), a);
                    goal = d;
                    if (d == axis_pos[a]) begin
                        run_state = msp_pkg::MODE_IDLE;
                        st        = msp_pkg::ST_THERE;
                    end else begin
                        dir_line         = $signed(d) < $signed(axis_pos[a]);
                        axis_enable_n[a] = 1'b0;
                        run_state        = msp_pkg::MODE_MOVE;
                        st               = msp_pkg::ST_MOVING;
                    end
                end else begin
                    run_state = msp_pkg::MODE_IDLE;
                    st        = msp_pkg::ST_BAD_POS;
                end
            end
            if (st == msp_pkg::ST_BAD_AXIS || st == msp_pkg::ST_BAD_POS)
                bad_commands++;
        end else begin
            a = cur_axis;
            case (run_state)
                msp_pkg::MODE_MOVE: begin
                    pulse = 1'b1;
                    take_step(a);
                    if (axis_pos[a] == goal)
                        start_wiggle();
                end
                msp_pkg::MODE_HOME: begin
                    if (rq.home_switch) begin
                        axis_enable_n[a] = 1'b0;
                        axis_pos[a]      = '0;
                        d                = switch_target(1, a);
                        goal             = d;
                        dir_line         = d[11];
                        st               = msp_pkg::ST_HOME_SEEN;
                        homes_found++;
                        if (d == '0)
                            start_wiggle();
                        else
                            run_state = msp_pkg::MODE_MOVE;
                    end else begin
                        // homing steps leave the position counter alone
                        pulse = 1'b1;
                    end
                end
                msp_pkg::MODE_WIGGLE: begin
                    pulse = 1'b1;
                    take_step(a);
                    if (wiggle_left > 0)
                        wiggle_left--;
                    if (wiggle_left == 0) begin
                        if (wiggle_pass == 0) begin
                            run_state        = msp_pkg::MODE_IDLE;
                            axis_enable_n[a] = 1'b1;
                            st               = msp_pkg::ST_MOVE_DONE;
                            moves_done++;
                        end else begin
                            last        = wiggle_pass;
                            wiggle_pass = wiggle_pass - 1;
                            wiggle_left = (wiggle_pass + last) * USTEPS;
                            dir_line    = (wiggle_pass % 2 == 0);
                        end
                    end
                end
                default: ;
            endcase
        end
        res.step_pulse      = pulse;
        res.direction       = dir_line;
        res.axis_index      = cur_axis;
        res.driver_enable_n = axis_enable_n[cur_axis];
        res.status          = st;
        res.position        = axis_pos[cur_axis];
        res.target          = goal;
    endfunction

    // request driver
    always @(posedge aclk) begin
        result_t predicted;
        logic    gap;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                advance_positioner(offered, predicted);
                expected_results.push_back(predicted);
                accepted_count++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                gap = (idle_phase == 2'd1 && $urandom_range(0, 99) < 77)
                   || (idle_phase == 2'd3 && $urandom_range(0, 99) < 11);
                if (pending_requests.size() != 0 && !gap) begin
                    offered = pending_requests.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= offered.opcode;
                    s_axis_tdata  <= {7'd0, offered.home_switch, offered.position_char,
                                      offered.axis_char};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        logic    stall;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.step_pulse      = m_axis_tdata[0];
                got.direction       = m_axis_tdata[1];
                got.axis_index      = m_axis_tdata[5:2];
                got.driver_enable_n = m_axis_tdata[6];
                got.status          = m_axis_tdata[9:7];
                got.position        = m_axis_tdata[21:10];
                got.target          = m_axis_tdata[33:22];
                result_count++;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d arrived with nothing expected: %h",
                                 result_count, m_axis_tdata);
                end else begin
                    want = expected_results.pop_front();
                    if (got.step_pulse !== want.step_pulse
                            || got.direction !== want.direction
                            || got.axis_index !== want.axis_index
                            || got.driver_enable_n !== want.driver_enable_n
                            || got.status !== want.status
                            || got.position !== want.position
                            || got.target !== want.target) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("result %0d: expected step=%b dir=%b axis=%0d en_n=%b st=%0d pos=%0d tgt=%0d",
                                     result_count, want.step_pulse, want.direction,
                                     want.axis_index, want.driver_enable_n, want.status,
                                     $signed(want.position), $signed(want.target));
                            $display("result %0d: got      step=%b dir=%b axis=%0d en_n=%b st=%0d pos=%0d tgt=%0d",
                                     result_count, got.step_pulse, got.direction,
                                     got.axis_index, got.driver_enable_n, got.status,
                                     $signed(got.position), $signed(got.target));
                        end
                    end
                end
            end
            stall = hold_off
                 || (idle_phase == 2'd2 && $urandom_range(0, 99) < 77)
                 || (idle_phase == 2'd3 && $urandom_range(0, 99) < 11);
            m_axis_tready <= !stall;
        end
    end

    // long receiver hold-off while the sender keeps offering
    initial begin
        while (accepted_count < 100)
            @(posedge aclk);
        hold_off <= 1'b1;
        repeat (300) @(posedge aclk);
        hold_off <= 1'b0;
    end

    initial begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end

    task automatic queue_request(input logic op, input logic [7:0] ac, input logic [7:0] pc,
                                 input logic sw);
        request_t rq;
        rq.opcode        = op;
        rq.axis_char     = ac;
        rq.position_char = pc;
        rq.home_switch   = sw;
        pending_requests.push_back(rq);
        pushed_count++;
    endtask

    task automatic queue_tick(input logic sw);
        queue_request(msp_pkg::OP_TICK, 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), sw);
    endtask

    task automatic queue_valid_command(input logic [7:0] pc);
        queue_request(msp_pkg::OP_COMMAND,
                      msp_pkg::CHAR_AXIS_FIRST + 8'($urandom_range(0, AXES - 1)), pc,
                      1'($urandom_range(0, 1)));
    endtask

    // tick until the predicted run settles or ITEMS requests are queued, the decision lags a few requests
    task automatic tick_until_rest();
        int cmd_seq;
        cmd_seq = pushed_count;
        while (accepted_count < cmd_seq)
            @(posedge aclk);
        while (run_state != msp_pkg::MODE_IDLE && pushed_count < ITEMS) begin
            if (pending_requests.size() < 8) begin
                repeat (16) begin
                    if (run_state == msp_pkg::MODE_HOME)
                        queue_tick($urandom_range(0, 29) == 0);
                    else
                        queue_tick(1'($urandom_range(0, 1)));
                end
            end
            @(posedge aclk);
        end
    endtask

    initial begin
        int kind;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: bad letters and characters, already there, homing, interrupted runs
        queue_tick(1'b0);
        queue_request(msp_pkg::OP_COMMAND, 8'h00, 8'hFF, 1'b1);
        queue_request(msp_pkg::OP_COMMAND, 8'hFF, msp_pkg::CHAR_HOME, 1'b0);
        queue_request(msp_pkg::OP_COMMAND, msp_pkg::CHAR_AXIS_FIRST - 8'd1,
                      msp_pkg::CHAR_POS_FIRST, 1'b0);
        queue_request(msp_pkg::OP_COMMAND, msp_pkg::CHAR_AXIS_LAST + 8'd1,
                      msp_pkg::CHAR_POS_FIRST, 1'b0);
        queue_request(msp_pkg::OP_COMMAND, msp_pkg::CHAR_AXIS_LAST,
                      msp_pkg::CHAR_POS_LAST + 8'd1, 1'b0);
        queue_request(msp_pkg::OP_COMMAND, msp_pkg::CHAR_AXIS_FIRST,
                      msp_pkg::CHAR_HOME - 8'd1, 1'b0);
        queue_request(msp_pkg::OP_COMMAND, msp_pkg::CHAR_AXIS_FIRST + 8'd1, 8'h00, 1'b0);
        // axis c at zero already sits on switch position 4
        queue_request(msp_pkg::OP_COMMAND, msp_pkg::CHAR_AXIS_FIRST + 8'd2,
                      msp_pkg::CHAR_HOME + 8'd4, 1'b0);
        queue_request(msp_pkg::OP_COMMAND, msp_pkg::CHAR_AXIS_FIRST + 8'd1,
                      msp_pkg::CHAR_HOME, 1'b0);
        queue_tick(1'b0);
        queue_tick(1'b0);
        queue_tick(1'b1);
        queue_tick(1'b1);
        queue_tick(1'b0);
        queue_request(msp_pkg::OP_COMMAND, msp_pkg::CHAR_AXIS_FIRST + 8'd10,
                      msp_pkg::CHAR_POS_LAST, 1'b0);
        repeat (3) queue_tick(1'b0);
        queue_request(msp_pkg::OP_COMMAND, msp_pkg::CHAR_AXIS_FIRST,
                      msp_pkg::CHAR_POS_FIRST, 1'b0);
        repeat (2) queue_tick(1'b0);
        // homing from a negative position steps upward
        queue_request(msp_pkg::OP_COMMAND, msp_pkg::CHAR_AXIS_FIRST, msp_pkg::CHAR_HOME, 1'b1);
        queue_tick(1'b0);
        queue_tick(1'b1);
        queue_tick(1'b0);
        // short move on axis e runs through the whole wiggle
        queue_request(msp_pkg::OP_COMMAND, msp_pkg::CHAR_AXIS_FIRST + 8'd4,
                      msp_pkg::CHAR_HOME + 8'd2, 1'b0);
        tick_until_rest();

        // random: complete runs and interrupted runs, some noise
        while (pushed_count < ITEMS) begin
            kind = $urandom_range(0, 99);
            if (kind < 10) begin
                if ($urandom_range(0, 1))
                    queue_request(msp_pkg::OP_COMMAND, 8'($urandom_range(0, 255)),
                                  8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                else
                    queue_tick(1'($urandom_range(0, 1)));
            end else if (kind < 20) begin
                queue_valid_command(8'($urandom_range(0, 255)));
            end else if (kind < 45) begin
                queue_valid_command(msp_pkg::CHAR_HOME + 8'($urandom_range(0, 11)));
                tick_until_rest();
            end else begin
                queue_valid_command(msp_pkg::CHAR_HOME + 8'($urandom_range(0, 11)));
                repeat ($urandom_range(1, 60))
                    queue_tick($urandom_range(0, 19) == 0);
            end
            while (pending_requests.size() > 32)
                @(posedge aclk);
        end

        while (pending_requests.size() != 0 || s_axis_tvalid)
            @(posedge aclk);
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (5) @(posedge aclk);

        $display("covered %0d requests: %0d bad commands, %0d homes found, %0d moves done",
                 accepted_count, bad_commands, homes_found, moves_done);
        $display("%0d results checked under four handshake pacing phases and one long stall",
                 result_count);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[multi_axis_stepper_positioner_unit.f]
+incdir+sv
sv/msp_pkg.sv
sv/multi_axis_stepper_positioner_unit.sv
tb/sv/tb_top.sv
